// ===== rtl/nec_ir_pulse_decoder_core_defines.svh =====
// Assertion macros used by the checker file of the IR decoder.
`ifndef NEC_IR_PULSE_DECODER_CORE_DEFINES_SVH
`define NEC_IR_PULSE_DECODER_CORE_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define NECIR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The same check, used for rules of the output handshake.
`define NECIR_ASSERT_HS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== rtl/necir_pkg.sv =====
package necir_pkg;

    // Frame geometry.
    localparam int WORD_BITS  = 32;
    localparam int FRAME_BITS = 32;
    localparam int CNT_BITS   = 6;
    localparam logic [CNT_BITS-1:0] FRAME_LOAD = CNT_BITS'(FRAME_BITS);

    // Event codes reported with each result.
    localparam logic [2:0] EV_IGNORED = 3'd0;
    localparam logic [2:0] EV_HEADER  = 3'd1;
    localparam logic [2:0] EV_BIT     = 3'd2;
    localparam logic [2:0] EV_ACCEPT  = 3'd3;
    localparam logic [2:0] EV_REJECT  = 3'd4;
    localparam logic [2:0] EV_REPEAT  = 3'd5;
    localparam logic [2:0] EV_DROP    = 3'd6;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEADER    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_REPEAT    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOLERANCE = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_ADDRESS   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_LONG      = 3'd5;

    typedef struct packed {
        logic [7:0] header_ticks;
        logic [7:0] repeat_ticks;
        logic [4:0] tolerance_ticks;
        logic [7:0] bit_threshold;
        logic [7:0] address_code;
        logic [7:0] long_press_count;
    } t_cfg;

    // Interval classification against the configured windows.
    typedef struct packed {
        logic header_hit;
        logic drop;
        logic repeat_hit;
        logic one_bit;
    } t_class;

    // Outcome of the frame word check.
    typedef struct packed {
        logic       pass;
        logic [7:0] command;
    } t_check;

endpackage

// ===== rtl/necir_cfg_regs.sv =====
module necir_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [necir_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [7:0]                          i_cfg_data,
    output necir_pkg::t_cfg                     o_cfg
);

    necir_pkg::t_cfg r_cfg;

    // Register file with reset defaults; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_ticks     <= 8'd108;
            r_cfg.repeat_ticks     <= 8'd90;
            r_cfg.tolerance_ticks  <= 5'd5;
            r_cfg.bit_threshold    <= 8'd13;
            r_cfg.address_code     <= 8'd0;
            r_cfg.long_press_count <= 8'd6;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                necir_pkg::REG_HEADER:    r_cfg.header_ticks     <= i_cfg_data;
                necir_pkg::REG_REPEAT:    r_cfg.repeat_ticks     <= i_cfg_data;
                necir_pkg::REG_TOLERANCE: r_cfg.tolerance_ticks  <= i_cfg_data[4:0];
                necir_pkg::REG_THRESHOLD: r_cfg.bit_threshold    <= i_cfg_data;
                necir_pkg::REG_ADDRESS:   r_cfg.address_code     <= i_cfg_data;
                necir_pkg::REG_LONG:      r_cfg.long_press_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/necir_classify.sv =====
module necir_classify (
    input  logic [7:0]          i_interval,
    input  necir_pkg::t_cfg     i_cfg,
    output necir_pkg::t_class   o_class
);

    logic [8:0] t9;
    logic [8:0] tol9;
    logic [8:0] hd9;
    logic [8:0] rp9;

    // Windows are compared at nine bits so that neither side wraps.
    always_comb begin
        t9   = {1'b0, i_interval};
        tol9 = {4'b0, i_cfg.tolerance_ticks};
        hd9  = {1'b0, i_cfg.header_ticks};
        rp9  = {1'b0, i_cfg.repeat_ticks};
        o_class.header_hit = ((t9 + tol9) >= hd9) && (t9 <= (hd9 + tol9));
        o_class.drop       = t9 > (rp9 + tol9);
        o_class.repeat_hit = (t9 + tol9) >= rp9;
        o_class.one_bit    = i_interval >= i_cfg.bit_threshold;
    end

endmodule

// ===== rtl/necir_check.sv =====
module necir_check (
    input  logic [necir_pkg::WORD_BITS-1:0] i_word,
    input  logic [7:0]                      i_address,
    output necir_pkg::t_check               o_check
);

    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;

    // Each inverted byte must complement its partner at eight bits, and the address byte must match.
    always_comb begin
        b0 = i_word[7:0];
        b1 = i_word[15:8];
        b2 = i_word[23:16];
        b3 = i_word[31:24];
        o_check.pass    = (b1 == ~b0) && (b3 == ~b2) && (b1 == i_address);
        o_check.command = b2;
    end

endmodule

// ===== rtl/nec_ir_pulse_decoder_core.sv =====
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_interval_ticks
// result    out        o_out_valid / i_out_ready  o_event_res, o_command, o_long_press
// config    in         i_cfg_we (no wait)         i_cfg_idx, i_cfg_data
//
// One interval is taken per cycle while o_in_ready is high.
// The input register feeds one pass of compare, shift and check logic into the result register.
// A stalled result holds its register; the input register still fills, then o_in_ready drops.
// Synchronous active-low reset clears the decoder state and loads the register defaults.
module nec_ir_pulse_decoder_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [7:0]                          i_interval_ticks,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [2:0]                          o_event_res,
    output logic [7:0]                          o_command,
    output logic                                o_long_press,
    input  logic                                i_cfg_we,
    input  logic [necir_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [7:0]                          i_cfg_data
);

    necir_pkg::t_cfg   cfg;
    necir_pkg::t_class cls;
    necir_pkg::t_check chk;

    // Input stage.
    logic       r_in_valid;
    logic [7:0] r_interval;

    // Decoder state.
    logic                               r_in_frame, n_in_frame;
    logic [necir_pkg::WORD_BITS-1:0]    r_shift_word, n_shift_word;
    logic [necir_pkg::CNT_BITS-1:0]     r_bits_left, n_bits_left;
    logic [7:0]                         r_repeat_count, n_repeat_count;
    logic                               r_acked, n_acked;
    logic                               r_long_flag, n_long_flag;

    // Result stage.
    logic       r_out_valid;
    logic [2:0] r_event_res, n_event_res;
    logic [7:0] r_command, n_command;
    logic       r_long_press;

    logic                            advance;
    logic [necir_pkg::WORD_BITS-1:0] shifted;
    logic [necir_pkg::WORD_BITS-1:0] check_word;

    necir_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    necir_classify u_classify (
        .i_interval (r_interval),
        .i_cfg      (cfg),
        .o_class    (cls)
    );

    necir_check u_check (
        .i_word    (check_word),
        .i_address (cfg.address_code),
        .o_check   (chk)
    );

    // The stored request moves on when the result register is free or drains now.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign shifted    = {cls.one_bit, r_shift_word[necir_pkg::WORD_BITS-1:1]};
    assign check_word = cls.repeat_hit ? r_shift_word : shifted;

    // Next state and event for the request in the input register.
    always_comb begin
        n_in_frame     = r_in_frame;
        n_shift_word   = r_shift_word;
        n_bits_left    = r_bits_left;
        n_repeat_count = r_repeat_count;
        n_acked        = r_acked;
        n_long_flag    = r_long_flag;
        n_event_res    = necir_pkg::EV_IGNORED;
        n_command      = 8'd0;
        if (!r_in_frame) begin
            if (cls.header_hit) begin
                n_in_frame   = 1'b1;
                n_shift_word = '0;
                n_acked      = 1'b0;
                n_bits_left  = necir_pkg::FRAME_LOAD;
                n_event_res  = necir_pkg::EV_HEADER;
            end
        end else if (cls.drop) begin
            n_in_frame  = 1'b0;
            n_event_res = necir_pkg::EV_DROP;
        end else if (cls.repeat_hit) begin
            if (r_repeat_count != 8'hFF) begin
                n_repeat_count = r_repeat_count + 8'd1;
            end
            n_event_res = necir_pkg::EV_REPEAT;
            if (n_repeat_count >= cfg.long_press_count) begin
                n_long_flag = 1'b1;
                n_in_frame  = 1'b0;
                if (!chk.pass) begin
                    n_event_res = necir_pkg::EV_REJECT;
                end else if (!r_acked) begin
                    n_acked     = 1'b1;
                    n_command   = chk.command;
                    n_event_res = necir_pkg::EV_ACCEPT;
                end
            end
        end else begin
            n_shift_word = shifted;
            n_bits_left  = r_bits_left - 1'b1;
            n_event_res  = necir_pkg::EV_BIT;
            if (n_bits_left == '0) begin
                n_in_frame = 1'b0;
                if (!chk.pass) begin
                    n_event_res = necir_pkg::EV_REJECT;
                end else if (r_acked) begin
                    n_event_res = necir_pkg::EV_REPEAT;
                end else begin
                    n_acked     = 1'b1;
                    n_command   = chk.command;
                    n_event_res = necir_pkg::EV_ACCEPT;
                end
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_interval <= i_interval_ticks;
        end
    end

    // Decoder state updates once per processed request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame     <= 1'b0;
            r_shift_word   <= '0;
            r_bits_left    <= '0;
            r_repeat_count <= 8'd0;
            r_acked        <= 1'b0;
            r_long_flag    <= 1'b0;
        end else if (advance) begin
            r_in_frame     <= n_in_frame;
            r_shift_word   <= n_shift_word;
            r_bits_left    <= n_bits_left;
            r_repeat_count <= n_repeat_count;
            r_acked        <= n_acked;
            r_long_flag    <= n_long_flag;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_event_res  <= n_event_res;
            r_command    <= n_command;
            r_long_press <= n_long_flag;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_res  = r_event_res;
    assign o_command    = r_command;
    assign o_long_press = r_long_press;

endmodule

// ===== rtl/necir_checker.sv =====
`include "nec_ir_pulse_decoder_core_defines.svh"

module necir_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_event_res,
    input logic [7:0] i_command,
    input logic       i_long_press
);

    // A stalled result keeps its event.
    `NECIR_ASSERT_HS(a_stall_hold, i_clk, i_rst_n,
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_event_res)),
        "stalled result changed")

    // Only defined event codes appear.
    `NECIR_ASSERT(a_event_range, i_clk, i_rst_n,
        i_out_valid |-> (i_event_res <= necir_pkg::EV_DROP),
        "undefined event code")

    // The command byte is zero unless a code was accepted.
    `NECIR_ASSERT(a_cmd_zero, i_clk, i_rst_n,
        (i_out_valid && (i_event_res != necir_pkg::EV_ACCEPT)) |-> (i_command == 8'd0),
        "command set without acceptance")

    // Once reported, the long-press flag stays set in later results.
    `NECIR_ASSERT(a_long_sticky, i_clk, i_rst_n,
        (i_out_valid && i_long_press) |=> (!i_out_valid || i_long_press),
        "long press flag cleared")

endmodule

bind nec_ir_pulse_decoder_core necir_checker u_necir_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .i_event_res  (o_event_res),
    .i_command    (o_command),
    .i_long_press (o_long_press)
);

// ===== test/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One decoded result as the block reports it.
    typedef struct packed {
        logic [2:0] code;
        logic [7:0] command;
        logic       long_press;
    } t_ir_event;

    // Interval classes under the current windows, used to build pulse trains.
    typedef enum int {
        PK_HEADER,
        PK_DROP,
        PK_REPEAT,
        PK_ONE,
        PK_ZERO
    } t_pulse_kind;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_in_valid;
    logic                               o_in_ready;
    logic [7:0]                         i_interval_ticks;
    logic                               o_out_valid;
    logic                               i_out_ready;
    logic [2:0]                         o_event_res;
    logic [7:0]                         o_command;
    logic                               o_long_press;
    logic                               i_cfg_we;
    logic [necir_pkg::CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [7:0]                         i_cfg_data;

    nec_ir_pulse_decoder_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_interval_ticks (i_interval_ticks),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_event_res      (o_event_res),
        .o_command        (o_command),
        .o_long_press     (o_long_press),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    // Decoder state mirrored by the testbench.
    necir_pkg::t_cfg cfg;
    logic        frame_open;
    logic [31:0] frame_word;
    logic [5:0]  bits_to_go;
    logic [7:0]  repeat_seen;
    logic        code_acked;
    logic        long_held;

    t_ir_event   pending_events[$];
    int unsigned event_tally[0:7];
    int          intervals_sent;
    int          busy_items;
    int          results_checked;
    int          fault_count;
    int          send_gap_pct;
    int          ready_gap_pct;
    int          hold_out_cycles;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Decoder state after reset, with the register defaults.
    function automatic void reset_model();
        cfg.header_ticks     = 8'd108;
        cfg.repeat_ticks     = 8'd90;
        cfg.tolerance_ticks  = 5'd5;
        cfg.bit_threshold    = 8'd13;
        cfg.address_code     = 8'd0;
        cfg.long_press_count = 8'd6;
        frame_open  = 1'b0;
        frame_word  = '0;
        bits_to_go  = '0;
        repeat_seen = '0;
        code_acked  = 1'b0;
        long_held   = 1'b0;
        for (int i = 0; i < 8; i++) event_tally[i] = 0;
    endfunction

    // Windows are open-ended where they would cross 0 or 255, so work in int.
    function automatic bit in_kind(int t, t_pulse_kind kind);
        int hd;
        int rp;
        int tol;
        int thr;
        hd  = int'(cfg.header_ticks);
        rp  = int'(cfg.repeat_ticks);
        tol = int'(cfg.tolerance_ticks);
        thr = int'(cfg.bit_threshold);
        case (kind)
            PK_HEADER: return t >= hd - tol && t <= hd + tol;
            PK_DROP:   return t > rp + tol;
            PK_REPEAT: return t >= rp - tol && t <= rp + tol;
            PK_ONE:    return t < rp - tol && t >= thr;
            default:   return t < rp - tol && t < thr;
        endcase
    endfunction

    // Uniform pick among the intervals of one class; any value if the class is empty.
    function automatic int pick_interval(t_pulse_kind kind);
        int hits;
        int n;
        hits = 0;
        for (int t = 0; t < 256; t++) begin
            if (in_kind(t, kind)) hits++;
        end
        if (hits == 0) return int'($urandom_range(0, 255));
        n = int'($urandom_range(0, hits - 1));
        for (int t = 0; t < 256; t++) begin
            if (in_kind(t, kind)) begin
                if (n == 0) return t;
                n--;
            end
        end
        return 0;
    endfunction

    // Closes the frame, checks the address and command complements at 8 bits and matches the address.
    function automatic logic [2:0] close_frame(output logic [7:0] cmd);
        cmd = 8'd0;
        frame_open = 1'b0;
        if (frame_word[15:8] != ~frame_word[7:0] ||
            frame_word[31:24] != ~frame_word[23:16] ||
            frame_word[15:8] != cfg.address_code) begin
            return necir_pkg::EV_REJECT;
        end
        if (code_acked) return necir_pkg::EV_REPEAT;
        code_acked = 1'b1;
        cmd = frame_word[23:16];
        return necir_pkg::EV_ACCEPT;
    endfunction

    // Expected result of one interval; advances the mirrored state.
    function automatic t_ir_event decode_interval(logic [7:0] t);
        t_ir_event  r;
        logic [7:0] cmd;
        r.code = necir_pkg::EV_IGNORED;
        cmd = 8'd0;
        if (!frame_open) begin
            if (in_kind(int'(t), PK_HEADER)) begin
                frame_open = 1'b1;
                frame_word = '0;
                code_acked = 1'b0;
                bits_to_go = necir_pkg::FRAME_LOAD;
                r.code = necir_pkg::EV_HEADER;
            end
        end else if (in_kind(int'(t), PK_DROP)) begin
            frame_open = 1'b0;
            r.code = necir_pkg::EV_DROP;
        end else if (in_kind(int'(t), PK_REPEAT)) begin
            // The repeat count saturates and is cleared by reset alone.
            if (repeat_seen != 8'hFF) repeat_seen++;
            r.code = necir_pkg::EV_REPEAT;
            if (repeat_seen >= cfg.long_press_count) begin
                long_held = 1'b1;
                r.code = close_frame(cmd);
            end
        end else begin
            // New bits enter at the top, so the first bit ends at bit 0.
            frame_word = {(t >= cfg.bit_threshold) ? 1'b1 : 1'b0, frame_word[31:1]};
            bits_to_go = bits_to_go - 6'd1;
            r.code = necir_pkg::EV_BIT;
            if (bits_to_go == 0) r.code = close_frame(cmd);
        end
        r.command    = cmd;
        r.long_press = long_held;
        event_tally[r.code]++;
        return r;
    endfunction

    function automatic logic [31:0] nec_code(logic [7:0] addr, logic [7:0] cmd);
        return {~cmd, cmd, addr, ~addr};
    endfunction

    // Offers one request and records its expected result once it is taken.
    task automatic send_interval(input logic [7:0] t);
        t_ir_event want;
        if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_interval_ticks <= t;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        want = decode_interval(t);
        pending_events.push_back(want);
        intervals_sent++;
        if (want.code != necir_pkg::EV_IGNORED) busy_items++;
        @(negedge i_clk);
    endtask

    // Header, then the low nbits of code first bit first, with repeats mixed in.
    task automatic send_frame(input logic [31:0] code, input int nbits, input int rpt_pct);
        send_interval(8'(pick_interval(PK_HEADER)));
        for (int i = 0; i < nbits; i++) begin
            if ($urandom_range(0, 99) < rpt_pct) send_interval(8'(pick_interval(PK_REPEAT)));
            send_interval(8'(pick_interval(code[i] ? PK_ONE : PK_ZERO)));
        end
    endtask

    // Stops sending and lets every outstanding request drain out of the block.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [necir_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [7:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        case (idx)
            necir_pkg::REG_HEADER:    cfg.header_ticks     = val;
            necir_pkg::REG_REPEAT:    cfg.repeat_ticks     = val;
            necir_pkg::REG_TOLERANCE: cfg.tolerance_ticks  = val[4:0];
            necir_pkg::REG_THRESHOLD: cfg.bit_threshold    = val;
            necir_pkg::REG_ADDRESS:   cfg.address_code     = val;
            necir_pkg::REG_LONG:      cfg.long_press_count = val;
            default: ;
        endcase
    endtask

    // The unused upper bits of the tolerance write get random values.
    task automatic load_settings(input logic [7:0] hd, input logic [7:0] rp,
                                 input logic [4:0] tol, input logic [7:0] thr,
                                 input logic [7:0] addr, input logic [7:0] lp);
        wait_idle();
        write_reg(necir_pkg::REG_HEADER, hd);
        write_reg(necir_pkg::REG_REPEAT, rp);
        write_reg(necir_pkg::REG_TOLERANCE, {3'($urandom), tol});
        write_reg(necir_pkg::REG_THRESHOLD, thr);
        write_reg(necir_pkg::REG_ADDRESS, addr);
        write_reg(necir_pkg::REG_LONG, lp);
    endtask

    // Mostly clean frames, plus corrupted and cut-short frames and noise.
    task automatic run_traffic(input int budget);
        int          goal;
        int          pick;
        logic [31:0] code;
        goal = busy_items + budget;
        while (busy_items < goal) begin
            pick = int'($urandom_range(0, 99));
            code = nec_code(($urandom_range(0, 9) == 0) ? 8'($urandom) : cfg.address_code,
                            8'($urandom));
            if (pick < 68) begin
                send_frame(code, 32, 2);
            end else if (pick < 80) begin
                send_frame(code ^ (32'd1 << $urandom_range(0, 31)), 32, 0);
            end else if (pick < 90) begin
                send_frame(code, int'($urandom_range(0, 31)), 12);
                send_interval(8'(pick_interval(PK_DROP)));
            end else begin
                repeat ($urandom_range(1, 8)) send_interval(8'($urandom));
            end
        end
    endtask

    // Edges of the header and repeat windows, field extremes and both bit values.
    task automatic test_window_edges();
        logic [7:0] pulses[16];
        pulses = '{8'd0, 8'd255, 8'd102, 8'd114, 8'd103, 8'd96, 8'd113, 8'd255,
                   8'd108, 8'd85, 8'd95, 8'd84, 8'd13, 8'd12, 8'd0, 8'd96};
        send_gap_pct  = 0;
        ready_gap_pct = 0;
        foreach (pulses[i]) send_interval(pulses[i]);
    endtask

    // A repeat that reaches the long-press count checks a partly filled word;
    // 24 bits leave a zero low byte, which passes with address 0xFF.
    task automatic test_long_press_accept();
        logic [7:0] cmd;
        cmd = 8'($urandom);
        load_settings(8'd108, 8'd90, 5'd5, 8'd13, 8'hFF, 8'd3);
        send_gap_pct  = 10;
        ready_gap_pct = 10;
        send_frame({8'h00, ~cmd, cmd, 8'hFF}, 24, 0);
        send_interval(8'd90);
    endtask

    task automatic test_nominal_traffic();
        load_settings(8'd108, 8'd90, 5'd5, 8'd13, 8'($urandom), 8'd255);
        send_gap_pct  = 20;
        ready_gap_pct = 20;
        run_traffic(380);
    endtask

    // Widest tolerance, top header value and a threshold of 100.
    task automatic test_wide_windows();
        load_settings(8'd255, 8'd200, 5'd31, 8'd100, 8'hFF, 8'd255);
        send_gap_pct  = 5;
        ready_gap_pct = 40;
        run_traffic(250);
    endtask

    // Windows that collapse to one value, leave no bit range or never drop.
    task automatic test_degenerate_windows();
        send_gap_pct  = 30;
        ready_gap_pct = 10;
        load_settings(8'd0, 8'd60, 5'd0, 8'd0, 8'h00, 8'd255);
        run_traffic(50);
        load_settings(8'd150, 8'd255, 5'd10, 8'd255, 8'($urandom), 8'd255);
        run_traffic(70);
        load_settings(8'd30, 8'd0, 5'd3, 8'd128, 8'($urandom), 8'd3);
        run_traffic(50);
    endtask

    task automatic test_single_repeat_press();
        load_settings(8'd200, 8'd120, 5'd8, 8'd40, 8'($urandom), 8'd1);
        send_gap_pct  = 10;
        ready_gap_pct = 0;
        run_traffic(180);
    endtask

    // With a count of zero every repeat ends the frame.
    task automatic test_zero_long_press();
        load_settings(8'd108, 8'd90, 5'd5, 8'd13, 8'($urandom), 8'd0);
        send_gap_pct  = 15;
        ready_gap_pct = 15;
        run_traffic(90);
    endtask

    // The result side holds off long enough for the block to stop taking requests.
    task automatic test_output_backpressure();
        load_settings(8'd108, 8'd90, 5'd5, 8'd13, 8'($urandom), 8'd255);
        send_gap_pct    = 0;
        ready_gap_pct   = 0;
        hold_out_cycles = 80;
        send_frame(nec_code(cfg.address_code, 8'($urandom)), 32, 0);
        send_frame(nec_code(cfg.address_code, 8'($urandom)), 32, 0);
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_back_to_back();
        load_settings(8'd108, 8'd90, 5'd5, 8'd13, 8'($urandom), 8'd255);
        send_gap_pct  = 0;
        ready_gap_pct = 0;
        run_traffic(300);
    endtask

    // Result-side ready: random short stalls, or one long requested hold-off.
    initial begin : out_ready_driver
        int n;
        i_out_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_out_cycles > 0) begin
                n = hold_out_cycles;
                hold_out_cycles = 0;
                i_out_ready <= 1'b0;
                repeat (n) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end else if (ready_gap_pct > 0 && $urandom_range(0, 99) < ready_gap_pct) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    // Each result is compared with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_ir_event want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_checked++;
            if (pending_events.size() == 0) begin
                if (fault_count < 10) begin
                    $display("%0t: result with nothing expected: event %0d command %h long %b",
                             $realtime, o_event_res, o_command, o_long_press);
                end
                fault_count++;
            end else begin
                want = pending_events.pop_front();
                if (o_event_res !== want.code || o_command !== want.command ||
                    o_long_press !== want.long_press) begin
                    if (fault_count < 10) begin
                        $display("%0t: mismatch: event %0d/%0d command %h/%h long %b/%b %s",
                                 $realtime, want.code, o_event_res, want.command, o_command,
                                 want.long_press, o_long_press, "(expected/actual)");
                    end
                    fault_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

    initial begin : run_tests
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_interval_ticks = 8'd0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = 8'd0;
        intervals_sent   = 0;
        busy_items       = 0;
        results_checked  = 0;
        fault_count      = 0;
        send_gap_pct     = 0;
        ready_gap_pct    = 0;
        hold_out_cycles  = 0;
        reset_model();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_window_edges();
        test_long_press_accept();
        test_nominal_traffic();
        test_wide_windows();
        test_degenerate_windows();
        test_single_repeat_press();
        test_zero_long_press();
        test_output_backpressure();
        test_back_to_back();

        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("summary: %0d intervals sent, %0d results checked under 10 register settings",
                 intervals_sent, results_checked);
        $display("summary: %0d headers, %0d bits, %0d accepted, %0d rejected, %0d repeats, %0d drops",
                 event_tally[necir_pkg::EV_HEADER], event_tally[necir_pkg::EV_BIT],
                 event_tally[necir_pkg::EV_ACCEPT], event_tally[necir_pkg::EV_REJECT],
                 event_tally[necir_pkg::EV_REPEAT], event_tally[necir_pkg::EV_DROP]);
        if (fault_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
